// ===== rtl/serial_code_generator_base62_top_assert.svh =====
// ----------------------------------------------------------------------------
// serial_code_generator_base62_top_assert.svh
// Assertion macros for the base-62 serial code generator
// ----------------------------------------------------------------------------
`ifndef SERIAL_CODE_GENERATOR_BASE62_TOP_ASSERT_SVH
`define SERIAL_CODE_GENERATOR_BASE62_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define SCG62_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression never true outside reset
`define SCG62_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define SCG62_ASSERT(lbl, prop, msg)
`define SCG62_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/scg62_pkg.sv =====
// ----------------------------------------------------------------------------
// scg62_pkg
// Types, constants and helper functions of the base-62 serial code generator
// ----------------------------------------------------------------------------
package scg62_pkg;

	localparam int MAX_MACHINE_CHARS_DEF = 4;
	localparam int MAX_VERSION_CHARS_DEF = 4;
	localparam int MAX_SERIAL_DIGITS_DEF = 11;
	localparam int MAX_CHECK_DIGITS_DEF  = 11;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CODE_W     = 32;
	localparam int LEN_W      = 3;
	localparam int DIGITS_W   = 4;
	localparam int PACK_BYTES = CODE_W / 8;

	localparam int CHAR_W   = 7;
	localparam int VALUE_W  = 64;
	localparam int DIGIT_W  = 6;
	localparam int CHUNK_W  = 16;
	localparam int CHUNKS   = VALUE_W / CHUNK_W;
	localparam int RECIP_W  = 23;
	localparam int DIV_SHIFT = 28;
	// ceil(2^28 / 62), exact for every dividend below 62 * 2^16
	localparam logic [RECIP_W-1:0] DIV_RECIP = 23'd4329605;

	localparam int HASH_SL  = 5;
	localparam int HASH_SR  = 27;
	localparam int SUM_SEED = 17;

	localparam logic [CODE_W-1:0]   MACHINE_CODE_RST  = 32'd12337;
	localparam logic [LEN_W-1:0]    MACHINE_LEN_RST   = 3'd2;
	localparam logic [CODE_W-1:0]   VERSION_CODE_RST  = 32'd48;
	localparam logic [LEN_W-1:0]    VERSION_LEN_RST   = 3'd1;
	localparam logic [DIGITS_W-1:0] SERIAL_DIGITS_RST = 4'd6;
	localparam logic [DIGITS_W-1:0] CHECK_DIGITS_RST  = 4'd2;

	localparam logic [62*8-1:0] ALPHA_STR =
		"XQWRyPlIY0Le9afUCKmnVZoDdMbFcivuJ5jx83NwBhAzrEHtksS21g7qOpGT46";

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_MACHINE_CODE  = 3'd0,
		REG_MACHINE_LEN   = 3'd1,
		REG_VERSION_CODE  = 3'd2,
		REG_VERSION_LEN   = 3'd3,
		REG_SERIAL_DIGITS = 3'd4,
		REG_CHECK_DIGITS  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] rem;
		logic [CHUNK_W-1:0] chunk;
	} div_req_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] quo;
		logic [DIGIT_W-1:0] rem;
	} div_rsp_t;

	// character of a base-62 digit, first alphabet entry in the top byte
	function automatic logic [CHAR_W-1:0] alpha_char(input logic [DIGIT_W-1:0] digit);
		logic [DIGIT_W-1:0] off;
		off = DIGIT_W'(61) - digit;
		return ALPHA_STR[{off, 3'b000} +: CHAR_W];
	endfunction

	// byte idx of a packed code word, low 7 bits; bytes above the word read as zero
	function automatic logic [CHAR_W-1:0] packed_char(input logic [CODE_W-1:0] word,
			input logic [3:0] idx);
		logic [CHAR_W-1:0] ch;
		if (idx < 4'(PACK_BYTES)) begin
			ch = word[{idx[1:0], 3'b000} +: CHAR_W];
		end else begin
			ch = '0;
		end
		return ch;
	endfunction

endpackage

// ===== rtl/serial_code_generator_base62_top.sv =====
// ----------------------------------------------------------------------------
// serial_code_generator_base62_top
// Base-62 serial code generator with check digits and character permutation
// ----------------------------------------------------------------------------
// Usage: write the six configuration registers through cfg_we / cfg_addr /
// cfg_wdata while busy is low. Pulse start with serial_value while busy is
// low; the transaction is taken at that edge and busy rises.
// The block then builds the code body in a small register file: machine
// characters one per cycle, serial and check digits through one shared
// divide-by-62 unit one 16-bit chunk at a time, the hash one character
// per cycle, and the permutation offset by a bit-serial modulo.
// Results come one character per cycle with char_valid high for one cycle,
// version characters first, then the permuted body; last_char marks the end.
// The receiver cannot stall; each character is shown for one cycle only.
// Reset returns the registers to their defaults and the sequencer to idle.
// ----------------------------------------------------------------------------
`include "serial_code_generator_base62_top_assert.svh"

module serial_code_generator_base62_top #(
	parameter int MAX_MACHINE_CHARS = scg62_pkg::MAX_MACHINE_CHARS_DEF,
	parameter int MAX_VERSION_CHARS = scg62_pkg::MAX_VERSION_CHARS_DEF,
	parameter int MAX_SERIAL_DIGITS = scg62_pkg::MAX_SERIAL_DIGITS_DEF,
	parameter int MAX_CHECK_DIGITS  = scg62_pkg::MAX_CHECK_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scg62_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [scg62_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              start,
	input  logic [scg62_pkg::VALUE_W-1:0]     serial_value,
	output logic                              busy,
	output logic                              char_valid,
	output logic [scg62_pkg::CHAR_W-1:0]      out_char,
	output logic                              last_char
);
	import scg62_pkg::*;

	localparam int BODY_MAX = MAX_MACHINE_CHARS + MAX_SERIAL_DIGITS + MAX_CHECK_DIGITS;
	localparam int IDX_W    = $clog2(BODY_MAX);
	localparam int TOT_W    = $clog2(BODY_MAX + 1);
	localparam int PW       = TOT_W + 1;
	localparam int SUM_MAX  = SUM_SEED + BODY_MAX * ((1 << CHAR_W) - 1);
	localparam int SUM_W    = $clog2(SUM_MAX + 1);
	localparam int CNT_MAX  = (BODY_MAX > SUM_W) ? BODY_MAX : SUM_W;
	localparam int CNT_W    = $clog2(CNT_MAX + 1);
	localparam int ML_W     = $clog2(MAX_MACHINE_CHARS + 1);
	localparam int VL_W     = $clog2(MAX_VERSION_CHARS + 1);
	localparam int SD_W     = $clog2(MAX_SERIAL_DIGITS + 1);
	localparam int CD_W     = $clog2(MAX_CHECK_DIGITS + 1);
	localparam int CHK_W    = $clog2(CHUNKS);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MACH = 8'b0000_0010,
		ST_SDIG = 8'b0000_0100,
		ST_HASH = 8'b0000_1000,
		ST_CDIG = 8'b0001_0000,
		ST_MOD  = 8'b0010_0000,
		ST_VOUT = 8'b0100_0000,
		ST_BOUT = 8'b1000_0000
	} state_t;

	// configuration registers
	logic [CODE_W-1:0]   machine_code_q;
	logic [LEN_W-1:0]    machine_len_q;
	logic [CODE_W-1:0]   version_code_q;
	logic [LEN_W-1:0]    version_len_q;
	logic [DIGITS_W-1:0] serial_digits_q;
	logic [DIGITS_W-1:0] check_digits_q;

	// sequencer and datapath
	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHK_W-1:0]    chunk_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [VALUE_W-1:0]  value_q;
	logic [VALUE_W-1:0]  hash_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TOT_W-1:0]    mod_q;
	logic [CHAR_W-1:0]   body_q [BODY_MAX];
	logic                char_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                last_char_q;

	logic [ML_W-1:0]     m_len;
	logic [VL_W-1:0]     v_len;
	logic [SD_W-1:0]     s_len;
	logic [CD_W-1:0]     c_len;
	logic [TOT_W-1:0]    total;
	logic [CNT_W-1:0]    cnt_nxt;
	logic [CHK_W-1:0]    chunk_sel;
	logic                chunk_last;
	logic                mach_last;
	logic                sdig_last;
	logic                hash_last;
	logic                cdig_last;
	logic                mod_last;
	logic                vout_last;
	logic                bout_last;
	div_req_t            div_req;
	div_rsp_t            div_rsp;
	logic                wr_en;
	logic [TOT_W-1:0]    wr_idx;
	logic [CHAR_W-1:0]   wr_char;
	logic [TOT_W-1:0]    rd_idx;
	logic [CHAR_W-1:0]   rd_char;
	logic [VALUE_W-1:0]  hash_nxt;
	logic [TOT_W:0]      mod_trial;
	logic [TOT_W-1:0]    mod_nxt;
	logic [PW-1:0]       px;
	logic [PW-1:0]       pl;
	logic [PW-1:0]       ptot;
	logic [PW-1:0]       pg;
	logic [PW-1:0]       phalf;
	logic [PW-1:0]       pf;
	logic [TOT_W-1:0]    perm_idx;

	// clamped lengths
	always_comb begin
		m_len = (int'(machine_len_q) > MAX_MACHINE_CHARS) ?
			ML_W'(MAX_MACHINE_CHARS) : ML_W'(machine_len_q);
		v_len = (int'(version_len_q) > MAX_VERSION_CHARS) ?
			VL_W'(MAX_VERSION_CHARS) : VL_W'(version_len_q);
		if (serial_digits_q == '0) begin
			s_len = SD_W'(1);
		end else if (int'(serial_digits_q) > MAX_SERIAL_DIGITS) begin
			s_len = SD_W'(MAX_SERIAL_DIGITS);
		end else begin
			s_len = SD_W'(serial_digits_q);
		end
		if (check_digits_q == '0) begin
			c_len = CD_W'(1);
		end else if (int'(check_digits_q) > MAX_CHECK_DIGITS) begin
			c_len = CD_W'(MAX_CHECK_DIGITS);
		end else begin
			c_len = CD_W'(check_digits_q);
		end
		total = TOT_W'(m_len) + TOT_W'(s_len) + TOT_W'(c_len);
	end

	always_comb begin
		cnt_nxt    = cnt_q + CNT_W'(1);
		chunk_sel  = CHK_W'(CHUNKS - 1) - chunk_q;
		chunk_last = (chunk_q == CHK_W'(CHUNKS - 1));
		mach_last  = (cnt_nxt == CNT_W'(m_len));
		sdig_last  = (cnt_nxt == CNT_W'(s_len));
		hash_last  = sdig_last;
		cdig_last  = (cnt_nxt == CNT_W'(c_len));
		mod_last   = (cnt_nxt == CNT_W'(SUM_W));
		vout_last  = (cnt_nxt == CNT_W'(v_len));
		bout_last  = (cnt_nxt == CNT_W'(total));
	end

	// shared divide-by-62 step
	always_comb begin
		div_req.rem   = rem_q;
		div_req.chunk = value_q[chunk_sel * CHUNK_W +: CHUNK_W];
	end

	scg62_div62 u_div62 (
		.req (div_req),
		.rsp (div_rsp)
	);

	// body write port; digits come least significant first, stored most significant first
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = TOT_W'(cnt_q);
		wr_char = alpha_char(div_rsp.rem);
		case (state_q)
			ST_MACH: begin
				wr_en   = 1'b1;
				wr_char = packed_char(machine_code_q, 4'(m_len) - 4'(1) - 4'(cnt_q));
			end
			ST_SDIG: begin
				wr_en  = chunk_last;
				wr_idx = TOT_W'(m_len) + TOT_W'(s_len) - TOT_W'(1) - TOT_W'(cnt_q);
			end
			ST_CDIG: begin
				wr_en  = chunk_last;
				wr_idx = total - TOT_W'(1) - TOT_W'(cnt_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// output position to body position: second swap loop, then the first
	always_comb begin
		px    = PW'(cnt_q);
		pl    = PW'(mod_q);
		ptot  = PW'(total);
		pg    = (px >= pl) ? (ptot + pl - PW'(1) - px) : px;
		phalf = pl >> 1;
		if (pg < phalf) begin
			pf = pl - pg;
		end else if ((pg > (pl - phalf)) && (pg <= pl)) begin
			pf = pl - pg;
		end else begin
			pf = pg;
		end
		perm_idx = pf[TOT_W-1:0];
	end

	always_comb begin
		rd_idx   = (state_q == ST_HASH) ? (TOT_W'(m_len) + TOT_W'(cnt_q)) : perm_idx;
		rd_char  = body_q[rd_idx[IDX_W-1:0]];
		hash_nxt = ((hash_q << HASH_SL) ^ (hash_q >> HASH_SR)) ^ VALUE_W'(rd_char);
		mod_trial = {mod_q, sum_q[SUM_W-1]};
		mod_nxt   = (mod_trial >= {1'b0, total}) ?
			TOT_W'(mod_trial - {1'b0, total}) : mod_trial[TOT_W-1:0];
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			machine_code_q  <= MACHINE_CODE_RST;
			machine_len_q   <= MACHINE_LEN_RST;
			version_code_q  <= VERSION_CODE_RST;
			version_len_q   <= VERSION_LEN_RST;
			serial_digits_q <= SERIAL_DIGITS_RST;
			check_digits_q  <= CHECK_DIGITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MACHINE_CODE:  machine_code_q  <= cfg_wdata[CODE_W-1:0];
				REG_MACHINE_LEN:   machine_len_q   <= cfg_wdata[LEN_W-1:0];
				REG_VERSION_CODE:  version_code_q  <= cfg_wdata[CODE_W-1:0];
				REG_VERSION_LEN:   version_len_q   <= cfg_wdata[LEN_W-1:0];
				REG_SERIAL_DIGITS: serial_digits_q <= cfg_wdata[DIGITS_W-1:0];
				REG_CHECK_DIGITS:  check_digits_q  <= cfg_wdata[DIGITS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			chunk_q      <= '0;
			char_valid_q <= 1'b0;
		end else begin
			char_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						chunk_q <= '0;
						state_q <= (m_len == '0) ? ST_SDIG : ST_MACH;
					end
				end
				ST_MACH: begin
					if (mach_last) begin
						cnt_q   <= '0;
						state_q <= ST_SDIG;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				ST_SDIG: begin
					chunk_q <= chunk_last ? '0 : chunk_q + CHK_W'(1);
					if (chunk_last) begin
						if (sdig_last) begin
							cnt_q   <= '0;
							state_q <= ST_HASH;
						end else begin
							cnt_q <= cnt_nxt;
						end
					end
				end
				ST_HASH: begin
					if (hash_last) begin
						cnt_q   <= '0;
						state_q <= ST_CDIG;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				ST_CDIG: begin
					chunk_q <= chunk_last ? '0 : chunk_q + CHK_W'(1);
					if (chunk_last) begin
						if (cdig_last) begin
							cnt_q   <= '0;
							state_q <= ST_MOD;
						end else begin
							cnt_q <= cnt_nxt;
						end
					end
				end
				ST_MOD: begin
					if (mod_last) begin
						cnt_q   <= '0;
						state_q <= (v_len == '0) ? ST_BOUT : ST_VOUT;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				ST_VOUT: begin
					char_valid_q <= 1'b1;
					if (vout_last) begin
						cnt_q   <= '0;
						state_q <= ST_BOUT;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				ST_BOUT: begin
					char_valid_q <= 1'b1;
					if (bout_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (wr_en) begin
			body_q[wr_idx[IDX_W-1:0]] <= wr_char;
		end
		case (state_q) inside
			ST_IDLE: begin
				if (start) begin
					value_q <= serial_value;
					rem_q   <= '0;
					sum_q   <= SUM_W'(SUM_SEED);
				end
			end
			ST_MACH: begin
				sum_q <= sum_q + SUM_W'(wr_char);
			end
			ST_SDIG, ST_CDIG: begin
				value_q[chunk_sel * CHUNK_W +: CHUNK_W] <= div_rsp.quo;
				rem_q  <= chunk_last ? '0 : div_rsp.rem;
				hash_q <= VALUE_W'(s_len);
				mod_q  <= '0;
				if (chunk_last) begin
					sum_q <= sum_q + SUM_W'(wr_char);
				end
			end
			ST_HASH: begin
				hash_q <= hash_nxt;
				if (hash_last) begin
					value_q <= hash_nxt;
				end
			end
			ST_MOD: begin
				mod_q <= mod_nxt;
				sum_q <= sum_q << 1;
			end
			ST_VOUT: begin
				out_char_q  <= packed_char(version_code_q, 4'(v_len) - 4'(1) - 4'(cnt_q));
				last_char_q <= 1'b0;
			end
			ST_BOUT: begin
				out_char_q  <= rd_char;
				last_char_q <= bout_last;
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign char_valid = char_valid_q;
	assign out_char   = out_char_q;
	assign last_char  = last_char_q;

	`SCG62_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
	`SCG62_ASSERT(a_last_gap, (char_valid && last_char) |=> !char_valid, "character after end of code")
	`SCG62_ASSERT_NEVER(a_perm_range, (state_q == ST_BOUT) && (perm_idx >= total), "permuted index out of body")

endmodule

// ===== rtl/scg62_div62.sv =====
// ----------------------------------------------------------------------------
// scg62_div62
// One long-division step by 62 on a 16-bit chunk with incoming remainder
// ----------------------------------------------------------------------------
module scg62_div62 (
	input  scg62_pkg::div_req_t req,
	output scg62_pkg::div_rsp_t rsp
);
	import scg62_pkg::*;

	localparam int X_W = DIGIT_W + CHUNK_W;

	logic [X_W-1:0]         x;
	logic [X_W+RECIP_W-1:0] prod;
	logic [CHUNK_W-1:0]     quo;
	logic [X_W-1:0]         quo_x62;
	logic [X_W-1:0]         rem_full;

	always_comb begin
		x        = {req.rem, req.chunk};
		prod     = (X_W+RECIP_W)'(x) * (X_W+RECIP_W)'(DIV_RECIP);
		quo      = prod[DIV_SHIFT +: CHUNK_W];
		// q * 62 = q * 64 - q * 2
		quo_x62  = {quo, 6'b000000} - {5'b00000, quo, 1'b0};
		rem_full = x - quo_x62;
		rsp.quo  = quo;
		rsp.rem  = rem_full[DIGIT_W-1:0];
	end

endmodule

// ===== sim/scg62_code_checker.sv =====
// ----------------------------------------------------------------------------
// scg62_code_checker
// Watches the register port, the start transaction and the character stream
// of the base-62 serial code generator. It keeps its own copy of the
// registers, builds the expected code string for each accepted serial value
// and compares every character and end flag in order.
// ----------------------------------------------------------------------------
module scg62_code_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scg62_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [scg62_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              start,
	input  logic [scg62_pkg::VALUE_W-1:0]     serial_value,
	input  logic                              busy,
	input  logic                              char_valid,
	input  logic [scg62_pkg::CHAR_W-1:0]      out_char,
	input  logic                              last_char,
	output int                                mismatches,
	output int                                chars_pending,
	output int                                codes_seen,
	output int                                chars_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import scg62_pkg::*;

	localparam int MAX_SHOWN = 50;
	localparam int BODY_LEN  = 26;
	localparam logic [62*8-1:0] DIGIT_SET =
		"XQWRyPlIY0Le9afUCKmnVZoDdMbFcivuJ5jx83NwBhAzrEHtksS21g7qOpGT46";

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              is_last;
		int unsigned       code_no;
		int unsigned       pos;
	} code_char_t;

	code_char_t code_chars_due[$];

	logic [31:0] machine_code_q;
	logic [2:0]  machine_len_q;
	logic [31:0] version_code_q;
	logic [2:0]  version_len_q;
	logic [3:0]  serial_digits_q;
	logic [3:0]  check_digits_q;

	function automatic logic [CHAR_W-1:0] digit_char(input int unsigned k);
		return DIGIT_SET[(61 - k) * 8 +: CHAR_W];
	endfunction

	// builds the whole expected string for one serial value
	function automatic void build_code(input logic [63:0] value);
		logic [CHAR_W-1:0] body [0:BODY_LEN-1];
		logic [CHAR_W-1:0] t;
		logic [63:0]       v;
		logic [63:0]       hash;
		code_char_t        item;
		int unsigned       m, vl, s, c, total, l, sum, i, j, stop, pos;
		m  = (machine_len_q > 3'd4) ? 4 : machine_len_q;
		vl = (version_len_q > 3'd4) ? 4 : version_len_q;
		s  = (serial_digits_q == 4'd0) ? 1 : (serial_digits_q > 4'd11) ? 11 : serial_digits_q;
		c  = (check_digits_q == 4'd0) ? 1 : (check_digits_q > 4'd11) ? 11 : check_digits_q;
		for (i = 0; i < BODY_LEN; i++)
			body[i] = '0;
		for (i = 0; i < m; i++)
			body[i] = machine_code_q[(m - 1 - i) * 8 +: CHAR_W];
		v = value;
		for (j = 0; j < s; j++) begin
			body[m + s - 1 - j] = digit_char(int'(v % 64'd62));
			v = v / 64'd62;
		end
		hash = 64'(s);
		for (i = 0; i < s; i++)
			hash = ((hash << 5) ^ (hash >> 27)) ^ 64'(body[m + i]);
		v = hash;
		for (j = 0; j < c; j++) begin
			body[m + s + c - 1 - j] = digit_char(int'(v % 64'd62));
			v = v / 64'd62;
		end
		total = m + s + c;
		sum = 17;
		for (i = 0; i < total; i++)
			sum += body[i];
		l = sum % total;
		for (i = 0; i < l / 2; i++) begin
			t = body[i];
			body[i] = body[l - i];
			body[l - i] = t;
		end
		stop = (total - l) / 2 + l;
		for (i = l; i < stop; i++) begin
			t = body[i];
			body[i] = body[total + l - i - 1];
			body[total + l - i - 1] = t;
		end
		pos = 0;
		for (i = 0; i < vl; i++) begin
			item.ch      = version_code_q[(vl - 1 - i) * 8 +: CHAR_W];
			item.is_last = 1'b0;
			item.code_no = codes_seen;
			item.pos     = pos;
			pos          = pos + 1;
			code_chars_due.push_back(item);
		end
		for (i = 0; i < total; i++) begin
			item.ch      = body[i];
			item.is_last = (i + 1 == total);
			item.code_no = codes_seen;
			item.pos     = pos;
			pos          = pos + 1;
			code_chars_due.push_back(item);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		code_char_t due;
		if (!arst_n) begin
			machine_code_q  <= 32'd12337;
			machine_len_q   <= 3'd2;
			version_code_q  <= 32'd48;
			version_len_q   <= 3'd1;
			serial_digits_q <= 4'd6;
			check_digits_q  <= 4'd2;
			code_chars_due.delete();
			mismatches    = 0;
			chars_pending = 0;
			codes_seen    = 0;
			chars_checked = 0;
		end else begin
			// the transaction uses the registers as they stand before this edge
			if (start && !busy) begin
				build_code(serial_value);
				codes_seen++;
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_MACHINE_CODE:  machine_code_q  <= cfg_wdata;
					REG_MACHINE_LEN:   machine_len_q   <= cfg_wdata[2:0];
					REG_VERSION_CODE:  version_code_q  <= cfg_wdata;
					REG_VERSION_LEN:   version_len_q   <= cfg_wdata[2:0];
					REG_SERIAL_DIGITS: serial_digits_q <= cfg_wdata[3:0];
					REG_CHECK_DIGITS:  check_digits_q  <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			if (char_valid) begin
				if (code_chars_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: unexpected char: expected none, got 0x%02h last %0b",
							$time, out_char, last_char);
				end else begin
					due = code_chars_due.pop_front();
					chars_checked++;
					if (out_char !== due.ch || last_char !== due.is_last) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("%0t: code %0d char %0d: expected 0x%02h last %0b, got 0x%02h last %0b",
								$time, due.code_no, due.pos, due.ch, due.is_last,
								out_char, last_char);
					end
				end
				if (mismatches == MAX_SHOWN + 1)
					$display("%0t: further mismatches are counted but not shown", $time);
			end
			chars_pending = code_chars_due.size();
		end
	end

endmodule

// ===== sim/serial_code_generator_base62_top_tb.sv =====
// ----------------------------------------------------------------------------
// serial_code_generator_base62_top_tb
// Drives serial values and register settings into the base-62 code generator:
// a directed part on the extremes and saturating lengths, then random values
// over random settings with varying sender gaps. The checker beside the block
// predicts and compares the character stream; this module gives the verdict.
// ----------------------------------------------------------------------------
module serial_code_generator_base62_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scg62_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 200;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_CODES    = 45;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr     = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  start        = 1'b0;
	logic [VALUE_W-1:0]    serial_value = '0;
	logic                  busy;
	logic                  char_valid;
	logic [CHAR_W-1:0]     out_char;
	logic                  last_char;

	int          mismatches;
	int          chars_pending;
	int          codes_seen;
	int          chars_checked;
	int unsigned idle_pct = 16;
	int unsigned quiet_cycles = 0;
	int unsigned settings_applied = 0;
	logic [63:0] pow62 [0:10];

	always #5 clk = ~clk;

	serial_code_generator_base62_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.serial_value (serial_value),
		.busy         (busy),
		.char_valid   (char_valid),
		.out_char     (out_char),
		.last_char    (last_char)
	);

	scg62_code_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.serial_value  (serial_value),
		.busy          (busy),
		.char_valid    (char_valid),
		.out_char      (out_char),
		.last_char     (last_char),
		.mismatches    (mismatches),
		.chars_pending (chars_pending),
		.codes_seen    (codes_seen),
		.chars_checked (chars_checked)
	);

	// counts cycles without any transaction on any port
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || char_valid || cfg_we))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d chars still due", $time, chars_pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_setting(input logic [31:0] mc, input logic [2:0] ml,
			input logic [31:0] vc, input logic [2:0] vl,
			input logic [3:0] sd, input logic [3:0] cd);
		write_reg(REG_MACHINE_CODE, mc);
		write_reg(REG_MACHINE_LEN, {29'd0, ml});
		write_reg(REG_VERSION_CODE, vc);
		write_reg(REG_VERSION_LEN, {29'd0, vl});
		write_reg(REG_SERIAL_DIGITS, {28'd0, sd});
		write_reg(REG_CHECK_DIGITS, {28'd0, cd});
		settings_applied++;
	endtask

	// one start transaction; returns at the edge that accepted it, start still high
	task automatic send_code(input logic [63:0] value);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 20)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			do @(negedge clk); while (busy);
			@(posedge clk);
			repeat (gap - 1) @(posedge clk);
		end
		start        <= 1'b1;
		serial_value <= value;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	// drop start and wait until every due char has come out
	task automatic drain_codes;
		start <= 1'b0;
		do @(negedge clk); while (chars_pending != 0 || busy);
		@(posedge clk);
	endtask

	function automatic logic [63:0] pick_value;
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = 64'($urandom_range(0, 61));
			1: v = pow62[$urandom_range(1, 10)] + 64'($urandom_range(0, 4)) - 64'd2;
			2: v = $urandom_range(0, 1) ? '1 : {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0,
				$urandom};
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	initial begin
		int unsigned k;
		pow62[0] = 64'd1;
		for (k = 1; k <= 10; k++)
			pow62[k] = pow62[k - 1] * 64'd62;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: wrap at six digits, extremes of the value
		send_code(64'd0);
		send_code('1);
		send_code(64'd61);
		send_code(64'd62);
		send_code(pow62[6] - 64'd1);
		send_code(pow62[6]);
		drain_codes();

		// widest strings, bytes with the top bit set and zero characters
		apply_setting(32'hC1_00_E2_7F, 3'd4, 32'h80_31_00_FF, 3'd4, 4'd11, 4'd11);
		send_code(64'd0);
		send_code('1);
		send_code(pow62[10] * 64'd61);
		drain_codes();

		// lengths and digit counts above their maximum saturate
		apply_setting(32'h4D_61_63_68, 3'd7, 32'h56_31_2E_30, 3'd5, 4'd15, 4'd15);
		send_code('1);
		send_code(64'h5555_5555_5555_5555);
		drain_codes();

		// zero digit counts clamp to one, empty machine and version
		apply_setting(32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF, 3'd0, 4'd0, 4'd0);
		send_code(64'd0);
		send_code(64'd61);
		send_code(64'd62);
		send_code(64'hAAAA_AAAA_AAAA_AAAA);
		drain_codes();

		apply_setting(32'h0000_0000, 3'd0, 32'h0000_0041, 3'd1, 4'd1, 4'd1);
		send_code(64'h8000_0000_0000_0000);
		send_code(64'h7FFF_FFFF_FFFF_FFFF);
		drain_codes();

		apply_setting(32'h3132_3334, 3'd6, 32'h7A7A_7A7A, 3'd7, 4'd12, 4'd1);
		send_code(64'h0123_4567_89AB_CDEF);
		send_code(64'hFEDC_BA98_7654_3210);
		drain_codes();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_pct = (phase < 3) ? 16 : (phase < 6) ? 50 : 0;
			apply_setting($urandom, 3'($urandom_range(0, 7)), $urandom,
				3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)));
			for (int n = 0; n < PHASE_CODES; n++)
				send_code(pick_value());
			drain_codes();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d codes, %0d chars checked, over %0d register settings",
			codes_seen, chars_checked, settings_applied);
		$display("sender gaps at 16, 50 and 0 percent; %0d mismatches", mismatches);
		if (mismatches == 0 && chars_pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
